@@ src/mcfp_pkg.sv @@
// Shared widths, register map and reset values of the motor command frame packer.
package mcfp_pkg;

	localparam int VAL_W      = 32;
	localparam int ID_W       = 11;
	localparam int GAIN_W     = 31;
	localparam int IN_DATA_W  = 176;
	localparam int OUT_DATA_W = 80;
	localparam int ADDR_W     = 5;

	localparam int POS_BITS_DEF   = 16;
	localparam int FIELD_BITS_DEF = 12;

	typedef enum logic [2:0] {
		REG_POS_MIN    = 3'd0,
		REG_POS_MAX    = 3'd1,
		REG_VEL_MIN    = 3'd2,
		REG_VEL_MAX    = 3'd3,
		REG_STIFF_MAX  = 3'd4,
		REG_DAMP_MAX   = 3'd5,
		REG_TORQUE_MIN = 3'd6,
		REG_TORQUE_MAX = 3'd7
	} reg_idx_t;

	localparam logic signed [VAL_W-1:0] POS_MIN_RST    = -32'sd823550;
	localparam logic signed [VAL_W-1:0] POS_MAX_RST    = 32'sd823550;
	localparam logic signed [VAL_W-1:0] VEL_MIN_RST    = -32'sd1966080;
	localparam logic signed [VAL_W-1:0] VEL_MAX_RST    = 32'sd1966080;
	localparam logic [GAIN_W-1:0]       STIFF_MAX_RST  = 31'd32768000;
	localparam logic [GAIN_W-1:0]       DAMP_MAX_RST   = 31'd6553600;
	localparam logic signed [VAL_W-1:0] TORQUE_MIN_RST = -32'sd1179648;
	localparam logic signed [VAL_W-1:0] TORQUE_MAX_RST = 32'sd1179648;

	function automatic int max_bits(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

@@ src/mcfp_quant.sv @@
// Clamp, offset and pipelined restoring divide for one set-point field.
module mcfp_quant #(
	parameter int BITS     = 12,
	parameter int LAT_BITS = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [31:0]  x,
	input  logic signed [32:0]  lo,
	input  logic signed [32:0]  hi,
	output logic [BITS-1:0]     code,
	output logic                err
);

	localparam int NW  = 32 + BITS;
	localparam int PAD = LAT_BITS - BITS;

	logic signed [33:0] xe, lo_e, hi_e, span_w, diff_w;
	logic [31:0]        d_s1, span_s1, span_s2;
	logic               err_s1, err_s2;
	logic [NW-1:0]      n_s2;

	assign xe     = {{2{x[31]}}, x};
	assign lo_e   = {lo[32], lo};
	assign hi_e   = {hi[32], hi};
	assign span_w = hi_e - lo_e;
	assign diff_w = xe - lo_e;

	// clamp into [lo, hi] and take the offset from lo
	always_ff @(posedge clk) begin
		if (en) begin
			err_s1  <= (hi_e <= lo_e);
			span_s1 <= span_w[31:0];
			if (xe < lo_e) begin
				d_s1 <= '0;
			end else if (xe > hi_e) begin
				d_s1 <= span_w[31:0];
			end else begin
				d_s1 <= diff_w[31:0];
			end
		end
	end

	// scale by 2^BITS - 1 as a shift and subtract
	always_ff @(posedge clk) begin
		if (en) begin
			n_s2    <= {d_s1, {BITS{1'b0}}} - {{BITS{1'b0}}, d_s1};
			span_s2 <= span_s1;
			err_s2  <= err_s1;
		end
	end

	logic [31:0]     rem_in [BITS];
	logic [31:0]     rem_s  [BITS];
	logic [BITS-1:0] low_in [BITS];
	logic [BITS-1:0] low_s  [BITS];
	logic [BITS-1:0] quo_in [BITS];
	logic [BITS-1:0] quo_s  [BITS];
	logic [31:0]     dv_in  [BITS];
	logic [31:0]     dv_s   [BITS];
	logic            er_in  [BITS];
	logic            er_s   [BITS];

	// one quotient bit per stage; the running remainder stays below the span
	for (genvar i = 0; i < BITS; i++) begin : g_div
		logic [32:0] trial, diff;
		logic        ge;
		if (i == 0) begin : g_first
			assign rem_in[i] = n_s2[NW-1:BITS];
			assign low_in[i] = n_s2[BITS-1:0];
			assign quo_in[i] = '0;
			assign dv_in[i]  = span_s2;
			assign er_in[i]  = err_s2;
		end else begin : g_next
			assign rem_in[i] = rem_s[i-1];
			assign low_in[i] = low_s[i-1];
			assign quo_in[i] = quo_s[i-1];
			assign dv_in[i]  = dv_s[i-1];
			assign er_in[i]  = er_s[i-1];
		end
		assign trial = {rem_in[i], low_in[i][BITS-1]};
		assign diff  = trial - {1'b0, dv_in[i]};
		assign ge    = (trial >= {1'b0, dv_in[i]});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? diff[31:0] : trial[31:0];
				low_s[i] <= {low_in[i][BITS-2:0], 1'b0};
				quo_s[i] <= {quo_in[i][BITS-2:0], ge};
				dv_s[i]  <= dv_in[i];
				er_s[i]  <= er_in[i];
			end
		end
	end

	logic [BITS-1:0] quo_last;
	logic            err_last;

	// hold narrower fields back so every field lines up with the widest field
	if (PAD > 0) begin : g_pad
		logic [BITS-1:0] pq_s [PAD];
		logic            pe_s [PAD];
		always_ff @(posedge clk) begin
			if (en) begin
				pq_s[0] <= quo_s[BITS-1];
				pe_s[0] <= er_s[BITS-1];
				for (int k = 1; k < PAD; k++) begin
					pq_s[k] <= pq_s[k-1];
					pe_s[k] <= pe_s[k-1];
				end
			end
		end
		assign quo_last = pq_s[PAD-1];
		assign err_last = pe_s[PAD-1];
	end else begin : g_nopad
		assign quo_last = quo_s[BITS-1];
		assign err_last = er_s[BITS-1];
	end

	assign code = err_last ? '0 : quo_last;
	assign err  = err_last;

endmodule

@@ src/motor_command_frame_packer.sv @@
// Top level: register file, set-point quantizers and CAN command frame assembly.
//
//  channel  dir  handshake                 payload
//  s_*      in   s_tvalid / s_tready       node id + five Q16.16 set-points (tdata)
//  m_*      out  m_tvalid / m_tready       frame id + eight data bytes (tdata), error (tuser)
//  apb      in   psel / penable / pready   eight limit registers, word aligned
//
// One beat enters per cycle while the output beat is not held; each result passes the
// clamp stage, the scale stage and the divider stages (padded to the longer of POS_BITS
// and FIELD_BITS), the restoring divider retiring one quotient bit per stage.
// Reset loads the default limits and empties the pipeline.
// A stalled output beat freezes the whole pipeline; nothing is dropped or repeated.
module motor_command_frame_packer #(
	parameter int POS_BITS   = mcfp_pkg::POS_BITS_DEF,
	parameter int FIELD_BITS = mcfp_pkg::FIELD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// node_id[10:0], pos_target[42:11], vel_target[74:43], stiff_gain[106:75],
	// damp_gain[138:107], torque_ff[170:139], zero fill
	input  logic [mcfp_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// frame_id[10:0], byte_0[18:11], byte_1[26:19], byte_2[34:27], byte_3[42:35],
	// byte_4[50:43], byte_5[58:51], byte_6[66:59], byte_7[74:67], zero fill
	output logic [mcfp_pkg::OUT_DATA_W-1:0]    m_tdata,
	// range_error[0]
	output logic [0:0]                         m_tuser,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mcfp_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import mcfp_pkg::*;

	localparam int LAT = max_bits(POS_BITS, FIELD_BITS);
	localparam int L   = LAT + 2;

	// limit registers
	logic signed [VAL_W-1:0] pos_min_q, pos_max_q, vel_min_q, vel_max_q;
	logic signed [VAL_W-1:0] torque_min_q, torque_max_q;
	logic [GAIN_W-1:0]       stiff_max_q, damp_max_q;
	reg_idx_t                idx;
	logic                    wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_min_q    <= POS_MIN_RST;
			pos_max_q    <= POS_MAX_RST;
			vel_min_q    <= VEL_MIN_RST;
			vel_max_q    <= VEL_MAX_RST;
			stiff_max_q  <= STIFF_MAX_RST;
			damp_max_q   <= DAMP_MAX_RST;
			torque_min_q <= TORQUE_MIN_RST;
			torque_max_q <= TORQUE_MAX_RST;
		end else if (wr) begin
			case (idx)
				REG_POS_MIN:    pos_min_q    <= pwdata;
				REG_POS_MAX:    pos_max_q    <= pwdata;
				REG_VEL_MIN:    vel_min_q    <= pwdata;
				REG_VEL_MAX:    vel_max_q    <= pwdata;
				REG_STIFF_MAX:  stiff_max_q  <= pwdata[GAIN_W-1:0];
				REG_DAMP_MAX:   damp_max_q   <= pwdata[GAIN_W-1:0];
				REG_TORQUE_MIN: torque_min_q <= pwdata;
				REG_TORQUE_MAX: torque_max_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_POS_MIN:    prdata = pos_min_q;
			REG_POS_MAX:    prdata = pos_max_q;
			REG_VEL_MIN:    prdata = vel_min_q;
			REG_VEL_MAX:    prdata = vel_max_q;
			REG_STIFF_MAX:  prdata = {1'b0, stiff_max_q};
			REG_DAMP_MAX:   prdata = {1'b0, damp_max_q};
			REG_TORQUE_MIN: prdata = torque_min_q;
			REG_TORQUE_MAX: prdata = torque_max_q;
			default:        prdata = '0;
		endcase
	end

	// advance every stage unless the output beat is held
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic [L-1:0]    vld_q;
	logic [ID_W-1:0] id_s [L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			id_s[0] <= s_tdata[10:0];
			for (int k = 1; k < L; k++) begin
				id_s[k] <= id_s[k-1];
			end
		end
	end

	assign m_tvalid = vld_q[L-1];

	// quantizers, one per set-point
	logic [POS_BITS-1:0]   p_code;
	logic [FIELD_BITS-1:0] v_code, kp_code, kd_code, t_code;
	logic                  p_err, v_err, kp_err, kd_err, t_err;

	mcfp_quant #(.BITS(POS_BITS), .LAT_BITS(LAT)) u_pos (
		.clk(clk), .en(en),
		.x(s_tdata[42:11]),
		.lo({pos_min_q[31], pos_min_q}), .hi({pos_max_q[31], pos_max_q}),
		.code(p_code), .err(p_err)
	);

	mcfp_quant #(.BITS(FIELD_BITS), .LAT_BITS(LAT)) u_vel (
		.clk(clk), .en(en),
		.x(s_tdata[74:43]),
		.lo({vel_min_q[31], vel_min_q}), .hi({vel_max_q[31], vel_max_q}),
		.code(v_code), .err(v_err)
	);

	mcfp_quant #(.BITS(FIELD_BITS), .LAT_BITS(LAT)) u_stiff (
		.clk(clk), .en(en),
		.x(s_tdata[106:75]),
		.lo('0), .hi({2'b00, stiff_max_q}),
		.code(kp_code), .err(kp_err)
	);

	mcfp_quant #(.BITS(FIELD_BITS), .LAT_BITS(LAT)) u_damp (
		.clk(clk), .en(en),
		.x(s_tdata[138:107]),
		.lo('0), .hi({2'b00, damp_max_q}),
		.code(kd_code), .err(kd_err)
	);

	mcfp_quant #(.BITS(FIELD_BITS), .LAT_BITS(LAT)) u_torque (
		.clk(clk), .en(en),
		.x(s_tdata[170:139]),
		.lo({torque_min_q[31], torque_min_q}), .hi({torque_max_q[31], torque_max_q}),
		.code(t_code), .err(t_err)
	);

	// pack big-endian: 16-bit position, then four 12-bit codes
	logic [15:0] p16;
	logic [11:0] v12, kp12, kd12, t12;

	assign p16  = 16'(p_code);
	assign v12  = 12'(v_code);
	assign kp12 = 12'(kp_code);
	assign kd12 = 12'(kd_code);
	assign t12  = 12'(t_code);

	assign m_tdata = {5'b0,
		t12[7:0], {kd12[3:0], t12[11:8]}, kd12[11:4], kp12[7:0],
		{v12[3:0], kp12[11:8]}, v12[11:4], p16[7:0], p16[15:8],
		id_s[L-1]};
	assign m_tuser = p_err | v_err | kp_err | kd_err | t_err;

`ifndef ASSERT_OFF
	// a held output beat must freeze the pipeline occupancy
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(vld_q))
		else $error("pipeline moved during output stall");

	// a bad position span flags the frame
	a_pos_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (pos_max_q <= pos_min_q) |-> m_tuser[0])
		else $error("position span error not flagged");

	// a bad position span zeroes the position code
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (pos_max_q <= pos_min_q) |-> (m_tdata[26:11] == 16'd0))
		else $error("position code not zero on span error");

	// good spans everywhere never flag an error
	a_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (pos_max_q > pos_min_q) && (vel_max_q > vel_min_q)
		&& (stiff_max_q != '0) && (damp_max_q != '0)
		&& (torque_max_q > torque_min_q) |-> !m_tuser[0])
		else $error("spurious range error");
`endif

endmodule
